### rtl/scfp_pkg.sv
// Shared types and constants for the sum16 checked frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

  // Reset value of the start delimiter register.
  localparam logic [7:0] DEFAULT_DELIMITER = 8'h7E;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CKLOW   = 3'd3,
    PH_CKHIGH  = 3'd4,
    PH_HALT    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_CK_GOOD   = 2'd1,
    KIND_CK_BAD    = 2'd2,
    KIND_BAD_START = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [7:0]  frame_length;
    logic [15:0] computed_sum;
    logic [15:0] received_checksum;
  } result_t;

endpackage

### rtl/scfp_fsm.sv
// Frame parsing state machine with running payload sum and checksum compare.
`timescale 1ns / 1ps

module scfp_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output scfp_pkg::result_t   res
);
  import scfp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  delim_r;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  cklow_r, cklow_nxt;
  logic [15:0] sum_add;
  logic [7:0]  remain_dec;
  logic [15:0] ck_word;

  assign sum_add    = sum_r + {8'd0, rx_byte};
  assign remain_dec = remain_r - 8'd1;
  assign ck_word    = {rx_byte, cklow_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      delim_r  <= DEFAULT_DELIMITER;
      length_r <= 8'd0;
      remain_r <= 8'd0;
      sum_r    <= 16'd0;
      cklow_r  <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        delim_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r  <= phase_nxt;
        length_r <= length_nxt;
        remain_r <= remain_nxt;
        sum_r    <= sum_nxt;
        cklow_r  <= cklow_nxt;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    cklow_nxt  = cklow_r;
    res_valid  = 1'b0;
    res        = '0;
    case (phase_r)
      PH_START: begin
        if (rx_byte == delim_r) begin
          phase_nxt = PH_LENGTH;
        end else begin
          res_valid      = 1'b1;
          res.kind       = KIND_BAD_START;
          res.byte_value = rx_byte;
          phase_nxt      = PH_HALT;
        end
      end
      PH_LENGTH: begin
        length_nxt = rx_byte;
        remain_nxt = rx_byte;
        sum_nxt    = 16'd0;
        phase_nxt  = (rx_byte == 8'd0) ? PH_CKLOW : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_nxt    = sum_add;
        remain_nxt = remain_dec;
        if (remain_dec == 8'd0) begin
          phase_nxt = PH_CKLOW;
        end
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.byte_value   = rx_byte;
        res.frame_length = length_r;
        res.computed_sum = sum_add;
      end
      PH_CKLOW: begin
        cklow_nxt = rx_byte;
        phase_nxt = PH_CKHIGH;
      end
      PH_CKHIGH: begin
        res_valid             = 1'b1;
        res.kind              = (ck_word == sum_r) ? KIND_CK_GOOD : KIND_CK_BAD;
        res.frame_length      = length_r;
        res.computed_sum      = sum_r;
        res.received_checksum = ck_word;
        phase_nxt             = PH_START;
      end
      default: begin
        // halted: drop every byte until reset
        phase_nxt = PH_HALT;
      end
    endcase
  end

endmodule

### rtl/scfp_out_stage.sv
// Result register between the parser and the output channel.
`timescale 1ns / 1ps

module scfp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  scfp_pkg::result_t   res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output scfp_pkg::result_t   out_res
);
  import scfp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

### rtl/sum16_checked_frame_parser.sv
// Top level of the sum16 checked frame parser.
`timescale 1ns / 1ps

// Parses a byte stream of frames: start delimiter, length byte, that many
// payload bytes, then a 16-bit additive checksum sent low byte first. Each
// payload byte comes out as a kind 0 result with the frame length and the
// wrapping 16-bit sum so far; the high checksum byte gives a kind 1 (good)
// or kind 2 (bad) result; delimiter, length and low checksum bytes give no
// result. A wrong start byte gives a kind 3 result carrying that byte, and
// the parser then drops all further bytes until reset. On each accepted
// request the state machine updates its phase, count and sum, and any
// result lands in a single output register. One byte per cycle is
// sustained as long as out_ready stays high; in_ready drops only while a
// result waits in the output register and out_ready is low. The start
// delimiter (reset 0x7E) is written through cfg_wr_en and cfg_wr_data,
// and should be changed only while no frame is in flight.
module sum16_checked_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // byte requests in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_computed_sum,
  output logic [15:0] out_received_checksum
);
  import scfp_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    room;

  // Take a byte whenever the output register can absorb a result this cycle.
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  scfp_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Hold each result until the downstream side takes it.
  scfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind              = out_res.kind;
  assign out_byte_value        = out_res.byte_value;
  assign out_frame_length      = out_res.frame_length;
  assign out_computed_sum      = out_res.computed_sum;
  assign out_received_checksum = out_res.received_checksum;

endmodule

### sim/testbench.sv
// Self-checking testbench for the sum16 checked frame parser.
`timescale 1ns / 1ps

module testbench;
  import scfp_pkg::*;

  localparam int N_REQUESTS   = 950;   // accepted bytes before the closing bad start byte
  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake before the run is abandoned
  localparam int SETTLE_CYCLES = 8;    // output register latency plus margin

  // Scoreboard: tracks the parser state from accepted requests and holds the
  // results those requests must produce, oldest first.
  class frame_scoreboard;
    logic [7:0]  delim;
    phase_t      phase;
    logic [7:0]  len_held;
    logic [7:0]  remaining;
    logic [15:0] sum;
    logic [7:0]  ck_low;
    result_t     pending_results[$];
    int          errors;

    function new();
      delim     = DEFAULT_DELIMITER;
      phase     = PH_START;
      len_held  = '0;
      remaining = '0;
      sum       = '0;
      ck_low    = '0;
      errors    = 0;
    endfunction

    function void set_delimiter(logic [7:0] value);
      delim = value;
    endfunction

    function bit halted();
      return phase != PH_START && phase != PH_LENGTH && phase != PH_PAYLOAD &&
             phase != PH_CKLOW && phase != PH_CKHIGH;
    endfunction

    function void note_request(logic [7:0] b);
      result_t r;
      logic [15:0] ck;
      r = '0;
      case (phase)
        PH_START: begin
          if (b == delim) begin
            phase = PH_LENGTH;
          end else begin
            r.kind       = KIND_BAD_START;
            r.byte_value = b;
            pending_results.push_back(r);
            phase = PH_HALT;
          end
        end
        PH_LENGTH: begin
          len_held  = b;
          remaining = b;
          sum       = '0;
          phase     = (b == 8'd0) ? PH_CKLOW : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum       = sum + {8'd0, b};
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = PH_CKLOW;
          r.kind         = KIND_PAYLOAD;
          r.byte_value   = b;
          r.frame_length = len_held;
          r.computed_sum = sum;
          pending_results.push_back(r);
        end
        PH_CKLOW: begin
          ck_low = b;
          phase  = PH_CKHIGH;
        end
        PH_CKHIGH: begin
          ck = {b, ck_low};
          r.kind              = (ck == sum) ? KIND_CK_GOOD : KIND_CK_BAD;
          r.frame_length      = len_held;
          r.computed_sum      = sum;
          r.received_checksum = ck;
          pending_results.push_back(r);
          phase = PH_START;
        end
        default: begin
          // halted: drop the byte
        end
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d byte=%02h", got.kind, got.byte_value));
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind)
          report($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.byte_value != want.byte_value)
          report($sformatf("byte_value got %02h want %02h", got.byte_value, want.byte_value));
        if (got.frame_length != want.frame_length)
          report($sformatf("frame_length got %0d want %0d",
                           got.frame_length, want.frame_length));
        if (got.computed_sum != want.computed_sum)
          report($sformatf("computed_sum got %04h want %04h",
                           got.computed_sum, want.computed_sum));
        if (got.received_checksum != want.received_checksum)
          report($sformatf("received_checksum got %04h want %04h",
                           got.received_checksum, want.received_checksum));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [7:0]  out_frame_length;
  logic [15:0] out_computed_sum;
  logic [15:0] out_received_checksum;

  frame_scoreboard sb;
  result_t         got_result;
  logic [7:0]      frame_bytes[$];   // payload of the frame being built
  logic [7:0]      line_delim;       // delimiter the stimulus currently frames with
  int              burst_left = 0;
  int              requests_sent = 0;
  int              idle_cycles = 0;

  sum16_checked_frame_parser u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_byte_value       (out_byte_value),
    .out_frame_length     (out_frame_length),
    .out_computed_sum     (out_computed_sum),
    .out_received_checksum(out_received_checksum)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one byte request and hold it until the parser takes it. The
  // sender runs in bursts; between bursts it may drop valid for a random
  // gap. Valid is raised at most once per step.
  task automatic send_request(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(40, 200);   // long stretch with no idling
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 20);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (!sb.halted()) requests_sent++;
    sb.note_request(b);
  endtask

  // Send delimiter, length, the payload held in frame_bytes and the checksum,
  // low byte first.
  task automatic send_frame(input logic [15:0] ck);
    send_request(line_delim);
    send_request(8'(frame_bytes.size()));
    foreach (frame_bytes[i]) send_request(frame_bytes[i]);
    send_request(ck[7:0]);
    send_request(ck[15:8]);
  endtask

  function automatic logic [15:0] payload_sum();
    logic [15:0] s;
    s = '0;
    foreach (frame_bytes[i]) s = s + {8'd0, frame_bytes[i]};
    return s;
  endfunction

  // Hold the sender off until every expected result has come out, then let
  // the output register settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the start delimiter while the parser sits idle between frames.
  task automatic write_delimiter(input logic [7:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_delimiter(value);
    line_delim = value;
  endtask

  function automatic logic [7:0] pick_delimiter();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return DEFAULT_DELIMITER;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: ready follows one of several patterns, each for a random span.
  initial begin
    int mode;
    int span;
    int k;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       out_ready <= 1'b1;                           // no stalls
          1:       out_ready <= 1'($urandom_range(0, 1));       // coin flip
          2:       out_ready <= ($urandom_range(0, 3) == 0);    // mostly stalled
          default: out_ready <= ((k % 7) < 4);                  // fixed duty pattern
        endcase
        @(posedge clk);
      end
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_result.kind              = kind_t'(out_kind);
      got_result.byte_value        = out_byte_value;
      got_result.frame_length      = out_frame_length;
      got_result.computed_sum      = out_computed_sum;
      got_result.received_checksum = out_received_checksum;
      sb.check_result(got_result);
    end
  end

  // Watchdog: abandon the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int mode;
    int next_cfg;
    int n;
    logic [15:0] ck;
    logic [7:0]  bad;
    sb = new();
    line_delim = DEFAULT_DELIMITER;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the reset delimiter.
    // Empty payload, good checksum: length goes straight to the checksum bytes.
    frame_bytes.delete();
    send_frame(16'h0000);
    // Empty payload, bad checksum.
    send_frame(16'h8001);
    // One all-ones payload byte, good checksum.
    frame_bytes.push_back(8'hFF);
    send_frame(payload_sum());
    // All-zeros byte and the delimiter value inside the payload; low
    // checksum byte off by one.
    frame_bytes.delete();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(DEFAULT_DELIMITER);
    send_frame(payload_sum() + 16'd1);

    // Delimiter at its extremes; the new value applies at the next start check.
    write_delimiter(8'hFF);
    frame_bytes.delete();
    frame_bytes.push_back(8'hAA);
    send_frame(payload_sum());
    write_delimiter(8'h00);

    // Random frames. Open with one full-length frame; otherwise keep most
    // frames short so the run stays fast.
    next_cfg = requests_sent + 150;
    len = 255;
    while (requests_sent < N_REQUESTS) begin
      if (requests_sent >= next_cfg) begin
        write_delimiter(pick_delimiter());
        next_cfg = requests_sent + $urandom_range(100, 250);
      end
      frame_bytes.delete();
      for (n = 0; n < len; n++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      ck   = payload_sum();
      mode = $urandom_range(0, 9);
      case (mode)
        6:       ck = ck ^ (16'd1 << $urandom_range(0, 15));   // single bit flip
        7:       ck[7:0]  = ck[7:0]  ^ 8'($urandom_range(1, 255));
        8:       ck[15:8] = ck[15:8] ^ 8'($urandom_range(1, 255));
        9:       ck = 16'($urandom_range(0, 65535));
        default: begin
          // keep the good checksum
        end
      endcase
      send_frame(ck);
      if ($urandom_range(0, 39) == 0) len = $urandom_range(128, 255);
      else len = $urandom_range(0, 12);
    end

    // Wrong start byte: report it once, then every further byte is dropped,
    // the delimiter value included. This goes last since only reset recovers.
    drain_results();
    bad = 8'($urandom_range(0, 255));
    if (bad == line_delim) bad = bad ^ 8'h01;
    send_request(bad);
    send_request(line_delim);
    for (n = 0; n < 6; n++) send_request(8'($urandom_range(0, 255)));

    // Drain and settle; anything left over or arriving late is a failure.
    drain_results();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/scfp_pkg.sv
rtl/scfp_fsm.sv
rtl/scfp_out_stage.sv
rtl/sum16_checked_frame_parser.sv
sim/testbench.sv
